### src/lss_pkg.sv
// Shared types and constants for the lidar sector steering block.
`timescale 1ns / 1ps
`default_nettype none

package lss_pkg;

    localparam int N_W        = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SPEED_W    = 10;
    localparam int RATE_W     = 11;
    localparam int MM_W       = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_RAY_COUNT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_FLOOR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_CEILING  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_CLEAR_MM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_NEAR_MM   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_SPEED   = 3'd5;

    localparam logic [N_W-1:0]     RST_RAY_COUNT      = 13'd720;
    localparam logic [MM_W-1:0]    RST_RANGE_FLOOR    = 16'd120;
    localparam logic [MM_W-1:0]    RST_RANGE_CEILING  = 16'd30000;
    localparam logic [MM_W-1:0]    RST_FRONT_CLEAR_MM = 16'd350;
    localparam logic [MM_W-1:0]    RST_SIDE_NEAR_MM   = 16'd120;
    localparam logic [SPEED_W-1:0] RST_CRUISE_SPEED   = 10'd100;

    localparam logic [N_W-1:0] MIN_RAYS = 13'd8;

    localparam int               RECIP3_W     = 16;
    localparam logic [15:0]      RECIP3       = 16'd43691;
    localparam int               RECIP3_SHIFT = 17;

    localparam int               PI_W      = 19;
    localparam logic [PI_W-1:0]  PI_SCALE  = 19'd314159;
    localparam int               DEN_W     = 21;
    localparam logic [7:0]       DEN_SCALE = 8'd200;

    localparam int DIV_STEPS = 11;
    localparam int STEP_W    = 4;

    localparam int                 SETTLE_W      = 2;
    localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;

    localparam logic [RATE_W-1:0] RATE_LIMIT = 11'd1000;
    localparam logic [RATE_W-1:0] NUDGE_RATE = 11'd100;

    typedef enum logic [1:0] {
        NUDGE_NONE,
        NUDGE_POS,
        NUDGE_NEG
    } lss_nudge_t;

    typedef struct packed {
        logic [N_W-1:0]     n;
        logic [N_W-1:0]     r_lo;
        logic [N_W-1:0]     r_hi;
        logic [N_W-1:0]     f_lo;
        logic [N_W-1:0]     f_hi;
        logic [N_W-1:0]     l_lo;
        logic [N_W-1:0]     l_hi;
        logic [MM_W-1:0]    range_floor;
        logic [MM_W-1:0]    range_ceiling;
        logic [MM_W-1:0]    front_clear;
        logic [MM_W-1:0]    side_near;
        logic [SPEED_W-1:0] cruise;
    } lss_cfg_t;

    typedef struct packed {
        logic accept;
        logic snap;
        logic mul;
        logic div_init;
        logic div_step;
        logic out_load;
    } lss_cmd_t;

endpackage

`default_nettype wire

### src/lss_if.sv
// Handshake channels of the lidar sector steering block: rays, steering results, register writes.
`timescale 1ns / 1ps
`default_nettype none

interface lss_ray_if #(parameter int RANGE_BITS = 16);
    logic                  valid;
    logic                  ready;
    logic [RANGE_BITS-1:0] range_mm;
    logic                  is_infinite;
    logic                  last_ray;

    modport source (output valid, output range_mm, output is_infinite, output last_ray,
                    input ready);
    modport sink   (input valid, input range_mm, input is_infinite, input last_ray,
                    output ready);
endinterface

interface lss_steer_if;
    logic                               valid;
    logic                               ready;
    logic [lss_pkg::SPEED_W-1:0]        linear_speed;
    logic signed [lss_pkg::RATE_W-1:0]  angular_rate;
    logic                               obstacle_ahead;

    modport source (output valid, output linear_speed, output angular_rate,
                    output obstacle_ahead, input ready);
    modport sink   (input valid, input linear_speed, input angular_rate,
                    input obstacle_ahead, output ready);
endinterface

interface lss_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lss_pkg::CFG_IDX_W-1:0]   index;
    logic [lss_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/lss_cfg_regs.sv
// Configuration registers and the derived sector bounds.
`timescale 1ns / 1ps
`default_nettype none

module lss_cfg_regs #(
    parameter int MAX_RAYS = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    lss_cfg_if.sink          cfg,
    output logic             written,
    output lss_pkg::lss_cfg_t cfg_out
);

    localparam int N_W = lss_pkg::N_W;
    localparam int MM_W = lss_pkg::MM_W;
    localparam int TN_W = N_W + 2;
    localparam int PR_W = N_W + lss_pkg::RECIP3_W;

    logic [N_W-1:0]              ray_count_reg;
    logic [MM_W-1:0]             range_floor_reg;
    logic [MM_W-1:0]             range_ceiling_reg;
    logic [MM_W-1:0]             front_clear_reg;
    logic [MM_W-1:0]             side_near_reg;
    logic [lss_pkg::SPEED_W-1:0] cruise_reg;

    logic [N_W-1:0] n_a_reg, n_a_next;
    logic [N_W-1:0] n_b_reg, r0_b_reg, f0_b_reg, l0_b_reg, seg_b_reg;
    logic [N_W-1:0] r0_b_next, f0_b_next, l0_b_next, seg_b_next;
    logic [N_W-1:0] n_c_reg, r_lo_reg, r_hi_reg, f_lo_reg, f_hi_reg, l_lo_reg, l_hi_reg;
    logic [N_W-1:0] half_c;
    logic [TN_W-1:0] three_n;
    logic [N_W-1:0]  diff;
    logic [PR_W-1:0] seg_prod;

    assign cfg.ready = 1'b1;
    assign written   = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ray_count_reg     <= lss_pkg::RST_RAY_COUNT;
            range_floor_reg   <= lss_pkg::RST_RANGE_FLOOR;
            range_ceiling_reg <= lss_pkg::RST_RANGE_CEILING;
            front_clear_reg   <= lss_pkg::RST_FRONT_CLEAR_MM;
            side_near_reg     <= lss_pkg::RST_SIDE_NEAR_MM;
            cruise_reg        <= lss_pkg::RST_CRUISE_SPEED;
        end
        else if (written)
        begin
            unique case (cfg.index)
                lss_pkg::CFG_RAY_COUNT:      ray_count_reg     <= cfg.data[N_W-1:0];
                lss_pkg::CFG_RANGE_FLOOR:    range_floor_reg   <= cfg.data[MM_W-1:0];
                lss_pkg::CFG_RANGE_CEILING:  range_ceiling_reg <= cfg.data[MM_W-1:0];
                lss_pkg::CFG_FRONT_CLEAR_MM: front_clear_reg   <= cfg.data[MM_W-1:0];
                lss_pkg::CFG_SIDE_NEAR_MM:   side_near_reg     <= cfg.data[MM_W-1:0];
                lss_pkg::CFG_CRUISE_SPEED:   cruise_reg        <= cfg.data[lss_pkg::SPEED_W-1:0];
                default:                     ;
            endcase
        end
    end

    // clamp ray count
    always_comb
    begin
        priority if (ray_count_reg < lss_pkg::MIN_RAYS)
            n_a_next = lss_pkg::MIN_RAYS;
        else if (32'(ray_count_reg) > 32'(MAX_RAYS))
            n_a_next = N_W'(MAX_RAYS);
        else
            n_a_next = ray_count_reg;
    end

    // quarter points and segment width, divide by three through the reciprocal
    always_comb
    begin
        three_n    = TN_W'(n_a_reg) + (TN_W'(n_a_reg) << 1);
        r0_b_next  = n_a_reg >> 2;
        f0_b_next  = n_a_reg >> 1;
        l0_b_next  = N_W'(three_n >> 2);
        diff       = l0_b_next - r0_b_next;
        seg_prod   = PR_W'(diff) * PR_W'(lss_pkg::RECIP3);
        seg_b_next = N_W'(seg_prod >> lss_pkg::RECIP3_SHIFT);
    end

    assign half_c = seg_b_reg >> 1;

    always_ff @(posedge clk)
    begin
        n_a_reg   <= n_a_next;
        n_b_reg   <= n_a_reg;
        r0_b_reg  <= r0_b_next;
        f0_b_reg  <= f0_b_next;
        l0_b_reg  <= l0_b_next;
        seg_b_reg <= seg_b_next;
        n_c_reg   <= n_b_reg;
        r_lo_reg  <= r0_b_reg;
        r_hi_reg  <= r0_b_reg + seg_b_reg;
        f_lo_reg  <= f0_b_reg - half_c;
        f_hi_reg  <= f0_b_reg + half_c;
        l_lo_reg  <= l0_b_reg - seg_b_reg;
        l_hi_reg  <= l0_b_reg;
    end

    always_comb
    begin
        cfg_out.n             = n_c_reg;
        cfg_out.r_lo          = r_lo_reg;
        cfg_out.r_hi          = r_hi_reg;
        cfg_out.f_lo          = f_lo_reg;
        cfg_out.f_hi          = f_hi_reg;
        cfg_out.l_lo          = l_lo_reg;
        cfg_out.l_hi          = l_hi_reg;
        cfg_out.range_floor   = range_floor_reg;
        cfg_out.range_ceiling = range_ceiling_reg;
        cfg_out.front_clear   = front_clear_reg;
        cfg_out.side_near     = side_near_reg;
        cfg_out.cruise        = cruise_reg;
    end

endmodule

`default_nettype wire

### src/lss_datapath.sv
// Sector trackers, heading multiply, restoring divider and result register.
`timescale 1ns / 1ps
`default_nettype none

module lss_datapath #(
    parameter int MAX_RAYS   = 4096,
    parameter int RANGE_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  lss_pkg::lss_cmd_t                 cmd,
    input  lss_pkg::lss_cfg_t                 cfg,
    input  wire logic [RANGE_BITS-1:0]        range_mm,
    input  wire logic                         is_infinite,
    input  wire logic                         last_ray,
    output logic [lss_pkg::SPEED_W-1:0]       linear_speed,
    output logic signed [lss_pkg::RATE_W-1:0] angular_rate,
    output logic                              obstacle_ahead
);

    localparam int N_W   = lss_pkg::N_W;
    localparam int IDX_W = $clog2(MAX_RAYS);
    localparam int BW    = (IDX_W > N_W) ? IDX_W : N_W;
    localparam int PW    = (RANGE_BITS > lss_pkg::MM_W) ? RANGE_BITS : lss_pkg::MM_W;
    localparam int MW    = (IDX_W + 1 > N_W) ? IDX_W + 1 : N_W;
    localparam int PRW   = MW + lss_pkg::PI_W;
    localparam int DSW   = lss_pkg::DEN_W + lss_pkg::DIV_STEPS + 1;
    localparam int RW    = (PRW > DSW) ? PRW : DSW;
    localparam int QW    = lss_pkg::DIV_STEPS;
    localparam int RTW   = lss_pkg::RATE_W;
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_RAYS - 1);

    logic [IDX_W-1:0] ray_index_reg, ray_index_next;
    logic [PW-1:0]    rp_reg, rl_reg, fl_reg, lp_reg, ll_reg;
    logic [PW-1:0]    rp_next, rl_next, fl_next, lp_next, ll_next;
    logic [IDX_W-1:0] rpr_reg, lpr_reg, rpr_next, lpr_next;

    logic                job_clear_reg;
    logic [IDX_W-1:0]    job_idx_reg;
    lss_pkg::lss_nudge_t job_nudge_reg, nudge_next;

    logic                           neg_reg, zero_reg;
    logic [PRW-1:0]                 prod_reg;
    logic [lss_pkg::DEN_W-1:0]      den_reg;
    logic [RW-1:0]                  rem_reg, dsh_reg;
    logic [QW-1:0]                  quo_reg;
    logic                           ovf_reg;

    logic [lss_pkg::SPEED_W-1:0] speed_reg;
    logic [RTW-1:0]              rate_reg, rate_next;
    logic                        obst_reg;

    logic          first;
    logic [BW-1:0] ib;
    logic          in_r, in_f, in_l;
    logic [PW-1:0] rng, cur_rp, cur_rl, cur_fl, cur_lp, cur_ll, near;
    logic [MW-1:0] two_idx, n_ext, mag;
    logic          neg_next, zero_next;
    logic [RTW-1:0] mag_rate, nudge_val;

    // sector update
    always_comb
    begin
        first  = (ray_index_reg == '0);
        ib     = BW'(ray_index_reg);
        rng    = PW'(range_mm);
        near   = PW'(cfg.side_near);
        cur_rp = first ? PW'(cfg.range_floor)   : rp_reg;
        cur_lp = first ? PW'(cfg.range_floor)   : lp_reg;
        cur_rl = first ? PW'(cfg.range_ceiling) : rl_reg;
        cur_fl = first ? PW'(cfg.range_ceiling) : fl_reg;
        cur_ll = first ? PW'(cfg.range_ceiling) : ll_reg;

        in_r = !is_infinite && (ib >= BW'(cfg.r_lo)) && (ib < BW'(cfg.r_hi));
        in_f = !is_infinite && (ib >= BW'(cfg.f_lo)) && (ib < BW'(cfg.f_hi));
        in_l = !is_infinite && (ib >= BW'(cfg.l_lo)) && (ib < BW'(cfg.l_hi));

        rp_next  = cur_rp;
        rpr_next = rpr_reg;
        if (in_r && (rng > cur_rp))
        begin
            rp_next  = rng;
            rpr_next = ray_index_reg;
        end
        lp_next  = cur_lp;
        lpr_next = lpr_reg;
        if (in_l && (rng > cur_lp))
        begin
            lp_next  = rng;
            lpr_next = ray_index_reg;
        end
        rl_next = (in_r && (rng < cur_rl)) ? rng : cur_rl;
        fl_next = (in_f && (rng < cur_fl)) ? rng : cur_fl;
        ll_next = (in_l && (rng < cur_ll)) ? rng : cur_ll;

        priority if (last_ray)
            ray_index_next = '0;
        else if (ray_index_reg != IDX_MAX)
            ray_index_next = ray_index_reg + 1'b1;
        else
            ray_index_next = ray_index_reg;

        priority if ((rl_next < near) && (ll_next > near))
            nudge_next = lss_pkg::NUDGE_POS;
        else if ((ll_next < near) && (rl_next > near))
            nudge_next = lss_pkg::NUDGE_NEG;
        else
            nudge_next = lss_pkg::NUDGE_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ray_index_reg <= '0;
            rpr_reg       <= '0;
            lpr_reg       <= '0;
        end
        else if (cmd.accept)
        begin
            ray_index_reg <= ray_index_next;
            rpr_reg       <= rpr_next;
            lpr_reg       <= lpr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rp_reg <= rp_next;
            rl_reg <= rl_next;
            fl_reg <= fl_next;
            lp_reg <= lp_next;
            ll_reg <= ll_next;
        end
        if (cmd.snap)
        begin
            job_clear_reg <= (fl_next > PW'(cfg.front_clear));
            job_idx_reg   <= (rp_next > lp_next) ? rpr_next : lpr_next;
            job_nudge_reg <= nudge_next;
        end
    end

    // heading offset times pi scale
    always_comb
    begin
        two_idx   = MW'(job_idx_reg) << 1;
        n_ext     = MW'(cfg.n);
        neg_next  = (two_idx < n_ext);
        zero_next = (two_idx == n_ext);
        mag       = neg_next ? (n_ext - two_idx) : (two_idx - n_ext);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            neg_reg  <= neg_next;
            zero_reg <= zero_next;
            prod_reg <= PRW'(mag) * PRW'(lss_pkg::PI_SCALE);
            den_reg  <= lss_pkg::DEN_W'(cfg.n) * lss_pkg::DEN_W'(lss_pkg::DEN_SCALE);
        end
        if (cmd.div_init)
        begin
            rem_reg <= RW'(prod_reg);
            dsh_reg <= RW'(den_reg) << (lss_pkg::DIV_STEPS - 1);
            quo_reg <= '0;
            ovf_reg <= (RW'(prod_reg) >= (RW'(den_reg) << lss_pkg::DIV_STEPS));
        end
        else if (cmd.div_step)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                quo_reg <= {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                quo_reg <= {quo_reg[QW-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    // saturate, sign and nudge selection
    always_comb
    begin
        priority if (ovf_reg || (RTW'(quo_reg) > lss_pkg::RATE_LIMIT))
            mag_rate = lss_pkg::RATE_LIMIT;
        else
            mag_rate = RTW'(quo_reg);

        unique case (job_nudge_reg)
            lss_pkg::NUDGE_POS: nudge_val = lss_pkg::NUDGE_RATE;
            lss_pkg::NUDGE_NEG: nudge_val = ~lss_pkg::NUDGE_RATE + 1'b1;
            default:            nudge_val = '0;
        endcase

        priority if (job_clear_reg || zero_reg)
            rate_next = nudge_val;
        else if (neg_reg)
            rate_next = ~mag_rate + 1'b1;
        else
            rate_next = mag_rate;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            speed_reg <= cfg.cruise;
            rate_reg  <= rate_next;
            obst_reg  <= !job_clear_reg;
        end
    end

    assign linear_speed   = speed_reg;
    assign angular_rate   = $signed(rate_reg);
    assign obstacle_ahead = obst_reg;

endmodule

`default_nettype wire

### src/lss_ctrl.sv
// Sequencer for ray intake, end-of-scan arithmetic and the result register.
`timescale 1ns / 1ps
`default_nettype none

module lss_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic         in_last,
    input  wire logic         out_ready,
    input  wire logic         cfg_write,
    output logic              in_ready,
    output logic              out_valid,
    output lss_pkg::lss_cmd_t cmd
);

    localparam logic [2:0] ST_RUN   = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_DINIT = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [lss_pkg::STEP_W-1:0] STEP_LAST =
        lss_pkg::STEP_W'(lss_pkg::DIV_STEPS - 1);

    logic [2:0]                     state_reg, state_next;
    logic [lss_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [lss_pkg::SETTLE_W-1:0]   settle_reg, settle_next;
    logic                           out_valid_reg, out_valid_next;

    always_comb
    begin
        in_ready     = (state_reg == ST_RUN) && (settle_reg == '0);
        cmd.accept   = in_valid && in_ready;
        cmd.snap     = cmd.accept && in_last;
        cmd.mul      = (state_reg == ST_MUL);
        cmd.div_init = (state_reg == ST_DINIT);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_RUN:
                if (cmd.snap)
                    state_next = ST_MUL;
            ST_MUL:
                state_next = ST_DINIT;
            ST_DINIT:
            begin
                state_next = ST_DIV;
                step_next  = '0;
            end
            ST_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                    state_next = ST_DONE;
            end
            ST_DONE:
                if (cmd.out_load)
                    state_next = ST_RUN;
            default:
                state_next = ST_RUN;
        endcase

        priority if (cfg_write)
            settle_next = lss_pkg::SETTLE_CYCLES;
        else if (settle_reg != '0)
            settle_next = settle_reg - 1'b1;
        else
            settle_next = settle_reg;

        priority if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            step_reg      <= '0;
            settle_reg    <= lss_pkg::SETTLE_CYCLES;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            settle_reg    <= settle_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_snap_starts_job: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.snap |=> (state_reg == ST_MUL))
        else $error("last ray did not start the heading job");

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken beat");

    a_settle_blocks_rays: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> !in_ready)
        else $error("ray taken while sector bounds settle");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (step_reg <= STEP_LAST))
        else $error("divider ran past its last step");

endmodule

`default_nettype wire

### src/lidar_sector_steering_core.sv
// Top level of the lidar sector steering block.
//
// Rays enter one per cycle while a scan runs; every ray, infinite or not, advances the ray
// counter. A ray flagged last closes the scan: ready then stays low through the multiply
// state, the divider set-up state and the 11 steps of the restoring divider that forms the turn
// rate, up to the load into the result register, and longer only if the previous result has
// not yet been taken. The result register lets the next scan's rays enter while a result waits.
// After reset and after every register write, ready stays low while the sector bounds are
// re-derived from the ray count.
`timescale 1ns / 1ps
`default_nettype none

module lidar_sector_steering_core #(
    parameter int MAX_RAYS   = 4096,
    parameter int RANGE_BITS = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lss_ray_if.sink     ray,
    lss_steer_if.source steer,
    lss_cfg_if.sink     cfg
);

    lss_pkg::lss_cfg_t cfg_vals;
    lss_pkg::lss_cmd_t cmd;
    logic              cfg_written;

    lss_cfg_regs #(
        .MAX_RAYS (MAX_RAYS)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .written (cfg_written),
        .cfg_out (cfg_vals)
    );

    lss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ray.valid),
        .in_last   (ray.last_ray),
        .out_ready (steer.ready),
        .cfg_write (cfg_written),
        .in_ready  (ray.ready),
        .out_valid (steer.valid),
        .cmd       (cmd)
    );

    lss_datapath #(
        .MAX_RAYS   (MAX_RAYS),
        .RANGE_BITS (RANGE_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg            (cfg_vals),
        .range_mm       (ray.range_mm),
        .is_infinite    (ray.is_infinite),
        .last_ray       (ray.last_ray),
        .linear_speed   (steer.linear_speed),
        .angular_rate   (steer.angular_rate),
        .obstacle_ahead (steer.obstacle_ahead)
    );

endmodule

`default_nettype wire
